FILE: design/hltrf_pkg.sv
// Package for the hex-length text record finder.
// Holds the channel payload types, the control structs and the byte classifiers.
// No dependencies.
`default_nettype none

package hltrf_pkg;

   localparam int HLTRF_BUF_DEPTH      = 4096;
   localparam int HLTRF_MAX_HEX_DIGITS = 6;
   localparam int HLTRF_HDR_LEN        = 4;
   localparam int HLTRF_START_W        = 12;
   localparam int HLTRF_LENGTH_W       = 13;

   localparam logic [7:0] HLTRF_HDR_CHAR  = 8'h46;
   localparam logic [7:0] HLTRF_REC_MARK  = 8'h00;
   localparam logic [7:0] HLTRF_COMMA     = 8'h2C;
   localparam logic [7:0] HLTRF_PRINT_LO  = 8'h20;
   localparam logic [7:0] HLTRF_PRINT_HI  = 8'h7E;
   localparam logic [7:0] HLTRF_HIGH_LO   = 8'h80;
   localparam logic [7:0] HLTRF_CHAR_TAB  = 8'h09;
   localparam logic [7:0] HLTRF_CHAR_LF   = 8'h0A;
   localparam logic [7:0] HLTRF_CHAR_CR   = 8'h0D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } hltrf_req_type;

   typedef struct packed {
      logic                      is_text;
      logic                      found;
      logic [HLTRF_START_W-1:0]  text_start;
      logic [HLTRF_LENGTH_W-1:0] text_length;
      logic                      overflow;
   } hltrf_rsp_type;

   typedef struct packed {
      logic go;
      logic is_text;
   } hltrf_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } hltrf_sts_type;

   function automatic logic hltrf_is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hltrf_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h57;
      end
      return v[3:0];
   endfunction

   function automatic logic hltrf_printable(input logic [7:0] c);
      return (c >= HLTRF_PRINT_LO && c <= HLTRF_PRINT_HI) || (c >= HLTRF_HIGH_LO) ||
             (c == HLTRF_CHAR_CR) || (c == HLTRF_CHAR_LF) || (c == HLTRF_CHAR_TAB);
   endfunction

endpackage

`default_nettype wire

FILE: design/hex_length_text_record_finder_top.sv
// Top level of the hex-length text record finder: byte loading, header and overflow
// tracking, result register. Depends on hltrf_pkg and hltrf_scan.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   hltrf_req_type (data_byte, last_byte)
//   rsp_     out        rsp_valid/rsp_stall   hltrf_rsp_type (is_text .. overflow)
//
// Loading takes one byte per cycle. After the last byte the scan walks the buffer through
// its single registered read port: it probes each start position for a record mark, and for each record
// candidate reads hex digits, checks comma and bound and judges the printable share. Input is stalled
// from the last byte until the result enters the output register, which frees on rsp_stall low.
// Reset is synchronous and needs no clearing pass: only bytes written for the current payload are read.
`default_nettype none

module hex_length_text_record_finder_top
   import hltrf_pkg::*;
#(
   parameter int BUF_DEPTH      = HLTRF_BUF_DEPTH,
   parameter int MAX_HEX_DIGITS = HLTRF_MAX_HEX_DIGITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire hltrf_req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output hltrf_rsp_type      rsp_data
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam int LW = 4 * MAX_HEX_DIGITS;

   logic [CW-1:0] count_ff, count_in;
   logic          hdr_bad_ff, hdr_bad_in;
   logic          ovf_ff, ovf_in;
   logic          busy_ff, busy_in;
   logic          is_text_ff, is_text_in;
   logic          ovf_cap_ff, ovf_cap_in;
   logic          rsp_valid_ff, rsp_valid_in;
   hltrf_rsp_type rsp_data_ff, rsp_data_in;

   logic          accept, room, last_tr, take;
   logic          bad_now, ovf_now;
   logic [CW-1:0] n_next;
   hltrf_cmd_type cmd;
   hltrf_sts_type sts;
   logic [CW-1:0] scan_start;
   logic [LW-1:0] scan_length;
   logic [31:0]   start_wide, length_wide;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !req_stall;
   assign room      = count_ff < CW'(BUF_DEPTH);
   assign last_tr   = accept && req_data.last_byte;
   assign n_next    = room ? count_ff + CW'(1) : count_ff;
   assign bad_now   = hdr_bad_ff ||
                      (count_ff < CW'(HLTRF_HDR_LEN) && req_data.data_byte != HLTRF_HDR_CHAR);
   assign ovf_now   = ovf_ff || !room;

   assign cmd.go      = last_tr;
   assign cmd.is_text = (n_next >= CW'(HLTRF_HDR_LEN)) && !bad_now;

   assign take = sts.done && (!rsp_valid_ff || !rsp_stall);

   hltrf_scan #(
      .BUF_DEPTH      (BUF_DEPTH),
      .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (accept && room),
      .wr_addr     (count_ff[AW-1:0]),
      .wr_data     (req_data.data_byte),
      .cmd         (cmd),
      .count       (n_next),
      .take        (take),
      .sts         (sts),
      .text_start  (scan_start),
      .text_length (scan_length)
   );

   assign start_wide  = 32'(scan_start);
   assign length_wide = 32'(scan_length);

   always_comb begin
      count_in     = count_ff;
      hdr_bad_in   = hdr_bad_ff;
      ovf_in       = ovf_ff;
      busy_in      = busy_ff;
      is_text_in   = is_text_ff;
      ovf_cap_in   = ovf_cap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         count_in   = n_next;
         hdr_bad_in = bad_now;
         ovf_in     = ovf_now;
      end
      if (last_tr) begin
         count_in   = '0;
         hdr_bad_in = 1'b0;
         ovf_in     = 1'b0;
         busy_in    = 1'b1;
         is_text_in = cmd.is_text;
         ovf_cap_in = ovf_now;
      end
      if (take) begin
         busy_in                 = 1'b0;
         rsp_valid_in            = 1'b1;
         rsp_data_in.is_text     = is_text_ff;
         rsp_data_in.found       = sts.found;
         rsp_data_in.text_start  = start_wide[HLTRF_START_W-1:0];
         rsp_data_in.text_length = length_wide[HLTRF_LENGTH_W-1:0];
         rsp_data_in.overflow    = ovf_cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         hdr_bad_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         is_text_ff   <= 1'b0;
         ovf_cap_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         hdr_bad_ff   <= hdr_bad_in;
         ovf_ff       <= ovf_in;
         busy_ff      <= busy_in;
         is_text_ff   <= is_text_in;
         ovf_cap_ff   <= ovf_cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_found_is_text : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.found |-> rsp_data_ff.is_text)
      else $error("record found in a payload without header");

   a_not_found_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |->
         rsp_data_ff.text_start == '0 && rsp_data_ff.text_length == '0)
      else $error("offset or length set without a record");

   a_last_stalls : assert property (@(posedge clock) disable iff (reset)
      last_tr |=> req_stall)
      else $error("input not held after last byte");

   a_take_frees : assert property (@(posedge clock) disable iff (reset)
      take |=> !req_stall && rsp_valid)
      else $error("result transfer did not release the input");

endmodule

`default_nettype wire

FILE: design/hltrf_scan.sv
// Payload buffer and record scan sequencer for the text record finder.
// One shared index adder/comparator steps the cursor; the buffer has one registered read port.
// Depends on hltrf_pkg.
`default_nettype none

module hltrf_scan
   import hltrf_pkg::*;
#(
   parameter int BUF_DEPTH      = HLTRF_BUF_DEPTH,
   parameter int MAX_HEX_DIGITS = HLTRF_MAX_HEX_DIGITS,
   localparam int AW = $clog2(BUF_DEPTH),
   localparam int CW = $clog2(BUF_DEPTH + 1),
   localparam int LW = 4 * MAX_HEX_DIGITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire hltrf_cmd_type cmd,
   input  wire logic [CW-1:0] count,
   input  wire logic          take,
   output hltrf_sts_type      sts,
   output logic [CW-1:0]      text_start,
   output logic [LW-1:0]      text_length
);

   localparam int DW = $clog2(MAX_HEX_DIGITS + 1);
   localparam int SW = ((CW > LW) ? CW : LW) + 1;
   localparam int JW = SW + 3;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PROBE = 3'd1;
   localparam logic [2:0] ST_DIGIT = 3'd2;
   localparam logic [2:0] ST_BOUND = 3'd3;
   localparam logic [2:0] ST_TEXT  = 3'd4;
   localparam logic [2:0] ST_JUDGE = 3'd5;
   localparam logic [2:0] ST_NEXT  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [7:0]    payload_mem_ff [BUF_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr_in;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] rs_ff, rs_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [LW-1:0] acc_ff, acc_in;
   logic [DW-1:0] dc_ff, dc_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [CW-1:0] pc_ff, pc_in;
   logic [CW-1:0] ts_ff, ts_in;
   logic          found_ff, found_in;

   logic [SW-1:0] op_a, op_b, sum, n_wide;
   logic          sum_lt_n, sum_gt_n;
   logic [CW-1:0] rs_inc;
   logic [JW-1:0] pc_x5, acc_x4;

   // shared index unit
   assign n_wide   = SW'(n_ff);
   assign sum      = op_a + op_b;
   assign sum_lt_n = sum < n_wide;
   assign sum_gt_n = sum > n_wide;

   assign rs_inc = rs_ff + CW'(1);
   assign pc_x5  = (JW'(pc_ff) << 2) + JW'(pc_ff);
   assign acc_x4 = JW'(acc_ff) << 2;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= payload_mem_ff[rd_addr_in];
   end

   always_comb begin
      op_a = SW'(cur_ff);
      op_b = SW'(1);
      case (state_ff)
         ST_PROBE: begin
            op_a = SW'(rs_ff);
         end
         ST_BOUND: begin
            op_b = SW'(acc_ff);
         end
         ST_NEXT: begin
            op_a = SW'(rs_ff);
            op_b = SW'(3);
         end
         default: begin
            op_a = SW'(cur_ff);
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      rs_in      = rs_ff;
      cur_in     = cur_ff;
      acc_in     = acc_ff;
      dc_in      = dc_ff;
      rem_in     = rem_ff;
      pc_in      = pc_ff;
      ts_in      = ts_ff;
      found_in   = found_ff;
      rd_addr_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.go) begin
               n_in     = count;
               rs_in    = '0;
               found_in = 1'b0;
               if (cmd.is_text && count > CW'(2)) begin
                  state_in = ST_PROBE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PROBE: begin
            if (rd_data_ff == HLTRF_REC_MARK) begin
               cur_in     = CW'(sum);
               acc_in     = '0;
               dc_in      = '0;
               rd_addr_in = sum[AW-1:0];
               state_in   = ST_DIGIT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_DIGIT: begin
            if (dc_ff < DW'(MAX_HEX_DIGITS) && hltrf_is_hex(rd_data_ff)) begin
               acc_in = LW'({acc_ff, hltrf_nibble(rd_data_ff)});
               dc_in  = dc_ff + DW'(1);
               cur_in = CW'(sum);
               if (sum_lt_n) begin
                  rd_addr_in = sum[AW-1:0];
               end else begin
                  state_in = ST_NEXT;
               end
            end else if (dc_ff == '0 || acc_ff == '0 || rd_data_ff != HLTRF_COMMA) begin
               state_in = ST_NEXT;
            end else begin
               cur_in   = CW'(sum);
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            if (sum_gt_n) begin
               state_in = ST_NEXT;
            end else begin
               ts_in      = cur_ff;
               rem_in     = acc_ff;
               pc_in      = '0;
               rd_addr_in = cur_ff[AW-1:0];
               state_in   = ST_TEXT;
            end
         end
         ST_TEXT: begin
            pc_in      = pc_ff + CW'(hltrf_printable(rd_data_ff));
            cur_in     = CW'(sum);
            rem_in     = rem_ff - LW'(1);
            rd_addr_in = sum[AW-1:0];
            if (rem_ff == LW'(1)) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            if (pc_x5 < acc_x4) begin
               state_in = ST_NEXT;
            end else begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_NEXT: begin
            if (sum_lt_n) begin
               rs_in      = rs_inc;
               rd_addr_in = rs_inc[AW-1:0];
               state_in   = ST_PROBE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         rs_ff    <= '0;
         cur_ff   <= '0;
         acc_ff   <= '0;
         dc_ff    <= '0;
         rem_ff   <= '0;
         pc_ff    <= '0;
         ts_ff    <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         rs_ff    <= rs_in;
         cur_ff   <= cur_in;
         acc_ff   <= acc_in;
         dc_ff    <= dc_in;
         rem_ff   <= rem_in;
         pc_ff    <= pc_in;
         ts_ff    <= ts_in;
         found_ff <= found_in;
      end
   end

   assign sts.done    = (state_ff == ST_DONE);
   assign sts.found   = found_ff;
   assign text_start  = found_ff ? ts_ff  : '0;
   assign text_length = found_ff ? acc_ff : '0;

endmodule

`default_nettype wire

FILE: verif/hex_length_text_record_finder_top_test.sv
`timescale 1ns / 100ps
// Testbench for hex_length_text_record_finder_top: streams byte payloads, predicts the
// header, record and overflow outcome of each one and checks every result transaction.
// Depends on hltrf_pkg and the design files only.

module hex_length_text_record_finder_top_test;
   import hltrf_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 20;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   hltrf_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   hltrf_rsp_type rsp_data;

   hltrf_req_type byte_queue[$];
   hltrf_rsp_type awaited_findings[$];
   logic [7:0]    build_buf[$];

   logic [7:0]    byte_store [0:HLTRF_BUF_DEPTH-1];
   int            stored_count = 0;
   logic          spilled = 1'b0;

   logic          req_taken = 1'b0;
   int            payloads_sent = 0;
   int            total_payloads = 0;
   int            sender_idle_pct = 0;
   int            receiver_idle_pct = 0;
   int            error_count = 0;
   int            cycle_count = 0;
   hltrf_rsp_type wanted;

   hex_length_text_record_finder_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int hex_weight(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   function automatic logic is_text_char(input logic [7:0] c);
      return (c >= 8'h20 && c <= 8'h7E) || c[7] || c == HLTRF_CHAR_CR ||
             c == HLTRF_CHAR_LF || c == HLTRF_CHAR_TAB;
   endfunction

   function automatic hltrf_rsp_type locate_text_record();
      hltrf_rsp_type res;
      int pos, cur, ndig, len, good, k;
      res = '0;
      res.overflow = spilled;
      if (stored_count >= HLTRF_HDR_LEN && byte_store[0] == HLTRF_HDR_CHAR &&
          byte_store[1] == HLTRF_HDR_CHAR && byte_store[2] == HLTRF_HDR_CHAR &&
          byte_store[3] == HLTRF_HDR_CHAR) begin
         res.is_text = 1'b1;
         for (pos = 0; pos + 2 < stored_count && !res.found; pos++) begin
            if (byte_store[pos] == HLTRF_REC_MARK) begin
               cur = pos + 1;
               len = 0;
               ndig = 0;
               while (cur < stored_count && ndig < HLTRF_MAX_HEX_DIGITS &&
                      hex_weight(byte_store[cur]) >= 0) begin
                  len = len * 16 + hex_weight(byte_store[cur]);
                  cur++;
                  ndig++;
               end
               if (ndig > 0 && len > 0 && cur < stored_count &&
                   byte_store[cur] == HLTRF_COMMA && cur + 1 + len <= stored_count) begin
                  cur++;
                  good = 0;
                  for (k = 0; k < len; k++) begin
                     if (is_text_char(byte_store[cur + k])) good++;
                  end
                  if (good * 5 >= len * 4) begin
                     res.found = 1'b1;
                     res.text_start = cur[HLTRF_START_W-1:0];
                     res.text_length = len[HLTRF_LENGTH_W-1:0];
                  end
               end
            end
         end
      end
      return res;
   endfunction

   task automatic take_byte(input hltrf_req_type t);
      if (stored_count < HLTRF_BUF_DEPTH) begin
         byte_store[stored_count] = t.data_byte;
         stored_count++;
      end else begin
         spilled = 1'b1;
      end
      if (t.last_byte) begin
         awaited_findings.push_back(locate_text_record());
         stored_count = 0;
         spilled = 1'b0;
         payloads_sent++;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic logic [7:0] hex_char(input int nib);
      if (nib < 10) return 8'(int'("0") + nib);
      if ($urandom_range(0, 1) != 0) return 8'(int'("A") + nib - 10);
      return 8'(int'("a") + nib - 10);
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0: return HLTRF_REC_MARK;
         1: return HLTRF_COMMA;
         2: return hex_char($urandom_range(0, 15));
         3: return HLTRF_HDR_CHAR;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] body_byte(input int bad_pct);
      logic [7:0] b;
      if ($urandom_range(0, 99) < bad_pct) begin
         b = 8'($urandom_range(0, 31));
         if (b == HLTRF_CHAR_TAB || b == HLTRF_CHAR_LF || b == HLTRF_CHAR_CR) b = 8'h7F;
         return b;
      end
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(8'h80, 8'hFF));
         1: begin
            case ($urandom_range(0, 2))
               0: return HLTRF_CHAR_TAB;
               1: return HLTRF_CHAR_LF;
               default: return HLTRF_CHAR_CR;
            endcase
         end
         default: return 8'($urandom_range(8'h20, 8'h7E));
      endcase
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) build_buf.push_back(s[i]);
   endtask

   task automatic add_record(input int value, input int ndig, input int body_len,
                             input int bad_pct, input bit with_comma);
      build_buf.push_back(HLTRF_REC_MARK);
      for (int i = ndig - 1; i >= 0; i--) build_buf.push_back(hex_char((value >> (4 * i)) & 15));
      if (with_comma) build_buf.push_back(HLTRF_COMMA);
      repeat (body_len) build_buf.push_back(body_byte(bad_pct));
   endtask

   task automatic flush_payload();
      hltrf_req_type t;
      foreach (build_buf[i]) begin
         t.data_byte = build_buf[i];
         t.last_byte = (i == build_buf.size() - 1);
         byte_queue.push_back(t);
      end
      build_buf.delete();
      total_payloads++;
   endtask

   // prediction and result checking
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         stored_count = 0;
         spilled = 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) take_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_findings.size() == 0) begin
               report_mismatch("result transaction with none awaited");
            end else begin
               wanted = awaited_findings.pop_front();
               if (rsp_data.is_text !== wanted.is_text)
                  report_mismatch($sformatf("is_text got %b want %b",
                                            rsp_data.is_text, wanted.is_text));
               if (rsp_data.found !== wanted.found)
                  report_mismatch($sformatf("found got %b want %b",
                                            rsp_data.found, wanted.found));
               if (rsp_data.text_start !== wanted.text_start)
                  report_mismatch($sformatf("text_start got %0d want %0d",
                                            rsp_data.text_start, wanted.text_start));
               if (rsp_data.text_length !== wanted.text_length)
                  report_mismatch($sformatf("text_length got %0d want %0d",
                                            rsp_data.text_length, wanted.text_length));
               if (rsp_data.overflow !== wanted.overflow)
                  report_mismatch($sformatf("overflow got %b want %b",
                                            rsp_data.overflow, wanted.overflow));
            end
         end
      end
   end

   // drive on the falling edge; hold a stalled transaction
   always @(negedge clock) begin
      if (payloads_sent * 3 < total_payloads) begin
         sender_idle_pct = 20;
         receiver_idle_pct = 71;
      end else if (payloads_sent * 3 < total_payloads * 2) begin
         sender_idle_pct = 71;
         receiver_idle_pct = 20;
      end else begin
         sender_idle_pct = 0;
         receiver_idle_pct = 0;
      end
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_data <= byte_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int random_bytes, random_payloads, value, body_len;

      build_buf.push_back(HLTRF_REC_MARK);
      flush_payload();
      add_text("FFF");
      flush_payload();
      add_text("FFFF");
      flush_payload();
      add_text("FFFf");
      add_record(3, 1, 3, 0, 1);
      flush_payload();
      add_text("FFFF");
      add_record(5, 1, 5, 0, 1);
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("a,abc");
      build_buf.push_back(HLTRF_CHAR_TAB);
      build_buf.push_back(HLTRF_CHAR_CR);
      build_buf.push_back(HLTRF_CHAR_LF);
      build_buf.push_back(8'h80);
      build_buf.push_back(8'hFF);
      build_buf.push_back(8'h7E);
      build_buf.push_back(8'h20);
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("0,x");
      add_record(1, 1, 1, 0, 1);
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("0000011,z");
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("000003,abc");
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text(",abc");
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("9,abc");
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("5,ABC");
      build_buf.push_back(8'h01);
      build_buf.push_back(8'h02);
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("5,ABCD");
      build_buf.push_back(8'h01);
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("3,");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("2,hi");
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("1,");
      flush_payload();
      add_text("FFEF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("1,a");
      flush_payload();
      add_text("FFFF");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("A,0123456789");
      flush_payload();
      add_text("FFFF");
      add_record(12'hFF0, 3, 12'hFF0, 0, 1);
      flush_payload();
      add_text("FFFF");
      repeat (HLTRF_BUF_DEPTH - 8) build_buf.push_back(8'($urandom_range(1, 255)));
      add_text("");
      build_buf.push_back(HLTRF_REC_MARK);
      add_text("1,Q");
      repeat (4) build_buf.push_back(8'($urandom_range(0, 255)));
      flush_payload();

      random_bytes = 0;
      random_payloads = 0;
      while (random_bytes < 850 || random_payloads < 40) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) build_buf.push_back(noise_byte());
         end else begin
            add_text("FFFF");
            if ($urandom_range(0, 8) == 0) build_buf[$urandom_range(0, 3)] = noise_byte();
            repeat ($urandom_range(0, 5)) build_buf.push_back(noise_byte());
            repeat ($urandom_range(1, 3)) begin
               value = $urandom_range(0, 24);
               body_len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, value) : value;
               add_record(value, $urandom_range(1, 7), body_len, $urandom_range(0, 40),
                          $urandom_range(0, 7) != 0);
            end
            repeat ($urandom_range(0, 4)) build_buf.push_back(noise_byte());
         end
         random_bytes += build_buf.size();
         random_payloads++;
         flush_payload();
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || req_valid || awaited_findings.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/hltrf_pkg.sv
design/hltrf_scan.sv
design/hex_length_text_record_finder_top.sv
verif/hex_length_text_record_finder_top_test.sv
